// ===== rtl/tbfr_pkg.sv =====
// Shared types, codes and helpers of the triple-buffer frame rotator.
`default_nettype none

package tbfr_pkg;

   // Field widths of the event and result beats.
   localparam int NUM_BUFFERS = 3;
   localparam int SEL_W       = 2;
   localparam int MODE_W      = 2;
   localparam int TIME_W      = 63;
   localparam int FRAME_W     = 32;
   localparam int INTERVAL_W  = 20;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 160;

   // Configuration port layout.
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic CSR_IDX_CAPTURE_ENABLED = 1'b0;
   localparam logic CSR_IDX_MAX_INTERVAL    = 1'b1;
   localparam logic [INTERVAL_W-1:0] MAX_INTERVAL_RESET = 20'd100000;

   // Event codes.
   localparam logic [MODE_W-1:0] MODE_FRAME_START     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CAPTURE_DONE    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PREPARE_DISPLAY = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESET_CAPTURE   = 2'd3;

   // Home positions of the three roles.
   localparam logic [SEL_W-1:0] ACTIVE_HOME  = 2'd0;
   localparam logic [SEL_W-1:0] DISPLAY_HOME = 2'd1;
   localparam logic [SEL_W-1:0] RENDER_HOME  = 2'd2;

   typedef struct packed {
      logic                  capture_enabled;
      logic [INTERVAL_W-1:0] max_interval_us;
   } cfg_type;

   // First member sits in the top bits, so accepted ends up in bit 0.
   typedef struct packed {
      logic [FRAME_W-1:0]    frame_count;
      logic [TIME_W-1:0]     render_timestamp_us;
      logic [INTERVAL_W-1:0] render_interval_us;
      logic [FRAME_W-1:0]    render_frame_id;
      logic                  render_ready;
      logic [SEL_W-1:0]      render_index;
      logic [SEL_W-1:0]      display_index;
      logic [SEL_W-1:0]      active_index;
      logic                  accepted;
   } rsp_type;

   // Maps an out-of-range buffer selector onto buffer 0.
   function automatic logic [SEL_W-1:0] sel_ok(input logic [SEL_W-1:0] s);
      return (s < SEL_W'(NUM_BUFFERS)) ? s : '0;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/triple_buffer_frame_rotator_core.sv =====
// Top level of the triple-buffer frame rotator: event stream in, role status out.
// An accepted event waits in the input register until the result register is free, then its result is registered there.
// One event per cycle while the result side keeps taking beats; the single-pass role update sets that figure.
// The input register takes a new beat while a finished result waits downstream.
// Reset is synchronous and active high: roles return to 0/1/2, flags, stored
// frame data, counters and configuration registers take their reset values.
`default_nettype none

module triple_buffer_frame_rotator_core
   import tbfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Event channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [62:0] time_us, [63] zero
   input  wire logic [MODE_W-1:0]     req_tuser,   // [1:0] mode
   // Result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] accepted, [2:1] active_index, [4:3] display_index, [6:5] render_index,
   // [7] render_ready, [39:8] render_frame_id, [59:40] render_interval_us,
   // [122:60] render_timestamp_us, [154:123] frame_count, [159:155] zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // Configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type             cfg;
   rsp_type             result;
   rsp_type             rsp_data_ff;
   logic                in_valid_ff, in_valid_in;
   logic [MODE_W-1:0]   in_mode_ff;
   logic [TIME_W-1:0]   in_time_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_fire;
   logic                advance;

   tbfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tbfr_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .mode    (in_mode_ff),
      .time_us (in_time_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Handshake: the held event moves on whenever the result register is free.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_mode_ff <= req_tuser;
         in_time_ff <= req_tdata[TIME_W-1:0];
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - $bits(rsp_type))'(0), rsp_data_ff};

   // The active buffer never shares a role with the render or display buffer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.active_index != rsp_data_ff.render_index &&
                        rsp_data_ff.active_index != rsp_data_ff.display_index))
      else $error("active buffer shares a role");

   // A non-zero interval is only reported for a ready render buffer.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.render_interval_us != '0) |->
         rsp_data_ff.render_ready)
      else $error("interval reported for a buffer that is not ready");

   // The event side only stalls when both stages are full and downstream stalls.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("event beat refused with room available");

   // A result beat follows each event that leaves the input register.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result beat missing after an event");

endmodule

`default_nettype wire

// ===== rtl/tbfr_csr.sv =====
// Configuration registers of the frame rotator behind an APB-style port.
`default_nettype none

module tbfr_csr
   import tbfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   logic                  capture_enabled_ff;
   logic [INTERVAL_W-1:0] max_interval_ff;
   logic                  write_en;
   logic                  reg_idx;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[2];

   // Register writes in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         capture_enabled_ff <= 1'b0;
         max_interval_ff    <= MAX_INTERVAL_RESET;
      end else if (write_en) begin
         unique case (reg_idx)
            CSR_IDX_CAPTURE_ENABLED: capture_enabled_ff <= csr_pwdata[0];
            CSR_IDX_MAX_INTERVAL:    max_interval_ff    <= csr_pwdata[INTERVAL_W-1:0];
            default: ;
         endcase
      end
   end

   // Read-back multiplexer.
   always_comb begin
      unique case (reg_idx)
         CSR_IDX_CAPTURE_ENABLED: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, capture_enabled_ff};
         CSR_IDX_MAX_INTERVAL:
            csr_prdata = {{(CSR_DATA_W-INTERVAL_W){1'b0}}, max_interval_ff};
         default: csr_prdata = '0;
      endcase
   end

   assign cfg.capture_enabled = capture_enabled_ff;
   assign cfg.max_interval_us = max_interval_ff;

endmodule

`default_nettype wire

// ===== rtl/tbfr_engine.sv =====
// Buffer role state and the per-event update of the frame rotator.
`default_nettype none

module tbfr_engine
   import tbfr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [MODE_W-1:0] mode,
   input  wire logic [TIME_W-1:0] time_us,
   input  cfg_type                cfg,
   output rsp_type                result
);

   logic [SEL_W-1:0]       active_sel_ff, active_sel_in;
   logic [SEL_W-1:0]       display_sel_ff, display_sel_in;
   logic [SEL_W-1:0]       render_sel_ff, render_sel_in;
   logic [NUM_BUFFERS-1:0] ready_ff, ready_in;
   logic [FRAME_W-1:0]     frame_number_ff [NUM_BUFFERS];
   logic [FRAME_W-1:0]     frame_number_in [NUM_BUFFERS];
   logic [INTERVAL_W-1:0]  interval_ff [NUM_BUFFERS];
   logic [INTERVAL_W-1:0]  interval_in [NUM_BUFFERS];
   logic [TIME_W-1:0]      done_time_ff [NUM_BUFFERS];
   logic [TIME_W-1:0]      done_time_in [NUM_BUFFERS];
   logic [FRAME_W-1:0]     completed_ff, completed_in;
   logic [TIME_W-1:0]      start_time_ff, start_time_in;
   logic                   start_seen_ff, start_seen_in;

   logic [SEL_W-1:0]       done_sel;
   logic [SEL_W-1:0]       shown_sel;
   logic [SEL_W-1:0]       next_active;
   logic [SEL_W-1:0]       out_sel;
   logic [TIME_W:0]        elapsed;
   logic                   interval_ok;
   logic [INTERVAL_W-1:0]  interval_val;
   logic                   accepted;
   logic                   out_ready;

   // State registers, updated once per event.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_sel_ff  <= ACTIVE_HOME;
         display_sel_ff <= DISPLAY_HOME;
         render_sel_ff  <= RENDER_HOME;
         ready_ff       <= '0;
         completed_ff   <= '0;
         start_time_ff  <= '0;
         start_seen_ff  <= 1'b0;
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            frame_number_ff[i] <= '0;
            interval_ff[i]     <= '0;
            done_time_ff[i]    <= '0;
         end
      end else if (step) begin
         active_sel_ff  <= active_sel_in;
         display_sel_ff <= display_sel_in;
         render_sel_ff  <= render_sel_in;
         ready_ff       <= ready_in;
         completed_ff   <= completed_in;
         start_time_ff  <= start_time_in;
         start_seen_ff  <= start_seen_in;
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            frame_number_ff[i] <= frame_number_in[i];
            interval_ff[i]     <= interval_in[i];
            done_time_ff[i]    <= done_time_in[i];
         end
      end
   end

   // Start-to-done interval: the borrow bit flags a done time before the start.
   assign done_sel     = sel_ok(active_sel_ff);
   assign shown_sel    = sel_ok(display_sel_ff);
   assign elapsed      = {1'b0, time_us} - {1'b0, start_time_ff};
   assign interval_ok  = start_seen_ff && !elapsed[TIME_W] &&
                         (elapsed[TIME_W-1:0] <= TIME_W'(cfg.max_interval_us));
   assign interval_val = interval_ok ? elapsed[INTERVAL_W-1:0] : '0;

   // Lowest buffer that is neither the render buffer nor the one just done.
   always_comb begin
      next_active = active_sel_ff;
      for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
         if (SEL_W'(i) != render_sel_ff && SEL_W'(i) != done_sel) begin
            next_active = SEL_W'(i);
         end
      end
   end

   // Next state for the event.
   always_comb begin
      active_sel_in   = active_sel_ff;
      display_sel_in  = display_sel_ff;
      render_sel_in   = render_sel_ff;
      ready_in        = ready_ff;
      frame_number_in = frame_number_ff;
      interval_in     = interval_ff;
      done_time_in    = done_time_ff;
      completed_in    = completed_ff;
      start_time_in   = start_time_ff;
      start_seen_in   = start_seen_ff;
      accepted        = 1'b0;
      unique case (mode)
         MODE_FRAME_START: begin
            start_time_in = time_us;
            start_seen_in = 1'b1;
            accepted      = 1'b1;
         end
         MODE_CAPTURE_DONE: begin
            if (cfg.capture_enabled) begin
               completed_in              = completed_ff + FRAME_W'(1);
               ready_in[done_sel]        = 1'b1;
               frame_number_in[done_sel] = completed_in;
               done_time_in[done_sel]    = time_us;
               interval_in[done_sel]     = interval_val;
               active_sel_in             = next_active;
               display_sel_in            = done_sel;
               ready_in[sel_ok(next_active)] = 1'b0;
               accepted                  = 1'b1;
            end
         end
         MODE_PREPARE_DISPLAY: begin
            if (ready_ff[shown_sel]) begin
               render_sel_in = shown_sel;
               accepted      = 1'b1;
            end
         end
         MODE_RESET_CAPTURE: begin
            if (cfg.capture_enabled) begin
               ready_in = '0;
               for (int i = 0; i < NUM_BUFFERS; i++) begin
                  interval_in[i] = '0;
               end
               active_sel_in  = ACTIVE_HOME;
               display_sel_in = DISPLAY_HOME;
               render_sel_in  = RENDER_HOME;
               start_time_in  = '0;
               start_seen_in  = 1'b0;
               accepted       = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Result reflects the state after the event.
   assign out_sel   = sel_ok(render_sel_in);
   assign out_ready = ready_in[out_sel];

   assign result.accepted            = accepted;
   assign result.active_index        = active_sel_in;
   assign result.display_index       = display_sel_in;
   assign result.render_index        = out_sel;
   assign result.render_ready        = out_ready;
   assign result.render_frame_id     = frame_number_in[out_sel];
   assign result.render_interval_us  = out_ready ? interval_in[out_sel] : '0;
   assign result.render_timestamp_us = done_time_in[out_sel];
   assign result.frame_count         = completed_in;

endmodule

`default_nettype wire

// ===== tb/sv/triple_buffer_frame_rotator_core_test.sv =====
// Self-checking testbench of the triple-buffer frame rotator: event stream in, role status out.

package frame_rotator_check_pkg;
   import tbfr_pkg::*;

   // Tracks the buffer roles and the per-buffer frame data, and keeps the status beats
   // still owed by the block.
   class frame_rotator_board;
      bit                    capture_on;
      bit [INTERVAL_W-1:0]   max_gap_us;
      bit [SEL_W-1:0]        active_buf;
      bit [SEL_W-1:0]        display_buf;
      bit [SEL_W-1:0]        render_buf;
      bit                    ready_flag [NUM_BUFFERS];
      bit [FRAME_W-1:0]      frame_no [NUM_BUFFERS];
      bit [INTERVAL_W-1:0]   gap_us [NUM_BUFFERS];
      bit [TIME_W-1:0]       done_at [NUM_BUFFERS];
      bit [FRAME_W-1:0]      frames_done;
      bit [TIME_W-1:0]       start_at;
      bit                    start_valid;
      rsp_type               status_q [$];
      int                    errors;

      function new();
         capture_on = 1'b0;
         max_gap_us = MAX_INTERVAL_RESET;
         send_roles_home();
         for (int b = 0; b < NUM_BUFFERS; b++) begin
            ready_flag[b] = 1'b0;
            frame_no[b]   = '0;
            gap_us[b]     = '0;
            done_at[b]    = '0;
         end
         frames_done = '0;
         start_at    = '0;
         start_valid = 1'b0;
         errors      = 0;
      endfunction

      function void send_roles_home();
         active_buf  = ACTIVE_HOME;
         display_buf = DISPLAY_HOME;
         render_buf  = RENDER_HOME;
      endfunction

      function int pending();
         return status_q.size();
      endfunction

      // Applies one accepted event and queues the status beat it must produce.
      function void note_event(logic [MODE_W-1:0] mode, logic [TIME_W-1:0] stamp);
         rsp_type         status;
         bit [TIME_W-1:0] span;
         bit [SEL_W-1:0]  sealed;
         bit              found;
         status = '0;
         case (mode)
            MODE_FRAME_START: begin
               start_at    = stamp;
               start_valid = 1'b1;
               status.accepted = 1'b1;
            end
            MODE_CAPTURE_DONE: begin
               if (capture_on) begin
                  sealed = active_buf;
                  span   = stamp - start_at;
                  frames_done++;
                  ready_flag[sealed] = 1'b1;
                  frame_no[sealed]   = frames_done;
                  done_at[sealed]    = stamp;
                  // The interval only counts when a start came first and it is in range.
                  if (start_valid && stamp >= start_at && span <= TIME_W'(max_gap_us))
                     gap_us[sealed] = span[INTERVAL_W-1:0];
                  else
                     gap_us[sealed] = '0;
                  // New active buffer: lowest one that is neither render nor just sealed.
                  found = 1'b0;
                  for (int b = 0; b < NUM_BUFFERS; b++) begin
                     if (!found && b != render_buf && b != sealed) begin
                        active_buf = SEL_W'(b);
                        found      = 1'b1;
                     end
                  end
                  display_buf = sealed;
                  ready_flag[active_buf] = 1'b0;
                  status.accepted = 1'b1;
               end
            end
            MODE_PREPARE_DISPLAY: begin
               if (ready_flag[display_buf]) begin
                  render_buf = display_buf;
                  status.accepted = 1'b1;
               end
            end
            MODE_RESET_CAPTURE: begin
               if (capture_on) begin
                  for (int b = 0; b < NUM_BUFFERS; b++) begin
                     ready_flag[b] = 1'b0;
                     gap_us[b]     = '0;
                  end
                  send_roles_home();
                  start_at    = '0;
                  start_valid = 1'b0;
                  status.accepted = 1'b1;
               end
            end
            default: ;
         endcase
         status.active_index        = active_buf;
         status.display_index       = display_buf;
         status.render_index        = render_buf;
         status.render_ready        = ready_flag[render_buf];
         status.render_frame_id     = frame_no[render_buf];
         status.render_interval_us  = ready_flag[render_buf] ? gap_us[render_buf] : '0;
         status.render_timestamp_us = done_at[render_buf];
         status.frame_count         = frames_done;
         status_q.push_back(status);
      endfunction

      task report(string what);
         errors++;
         if (errors <= 100)
            $display("ERROR at %0t: %s", $time, what);
      endtask

      task check_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report($sformatf("%s is %0h, should be %0h", name, got, want));
      endtask

      // Compares one status beat with the oldest one owed.
      task check_result(logic [RSP_DATA_W-1:0] beat);
         rsp_type got;
         rsp_type want;
         if (status_q.size() == 0) begin
            report("status beat arrived with no event outstanding");
            return;
         end
         got  = beat[$bits(rsp_type)-1:0];
         want = status_q.pop_front();
         check_field("padding", 64'(beat[RSP_DATA_W-1:$bits(rsp_type)]), '0);
         check_field("accepted", 64'(got.accepted), 64'(want.accepted));
         check_field("active_index", 64'(got.active_index), 64'(want.active_index));
         check_field("display_index", 64'(got.display_index), 64'(want.display_index));
         check_field("render_index", 64'(got.render_index), 64'(want.render_index));
         check_field("render_ready", 64'(got.render_ready), 64'(want.render_ready));
         check_field("render_frame_id", 64'(got.render_frame_id),
                     64'(want.render_frame_id));
         check_field("render_interval_us", 64'(got.render_interval_us),
                     64'(want.render_interval_us));
         check_field("render_timestamp_us", 64'(got.render_timestamp_us),
                     64'(want.render_timestamp_us));
         check_field("frame_count", 64'(got.frame_count), 64'(want.frame_count));
      endtask
   endclass

endpackage

module triple_buffer_frame_rotator_core_test;
   import tbfr_pkg::*;
   import frame_rotator_check_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_ADDR_W-1:0] ADDR_CAPTURE_ENABLED = {CSR_IDX_CAPTURE_ENABLED, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_INTERVAL    = {CSR_IDX_MAX_INTERVAL, 2'b00};
   localparam logic [TIME_W-1:0]     TIME_TOP             = {TIME_W{1'b1}};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;    // [62:0] time_us, [63] zero
   logic [MODE_W-1:0]     req_tuser = '0;    // [1:0] mode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [0] accepted, [2:1] active_index, [4:3] display_index, [6:5] render_index,
   // [7] render_ready, [39:8] render_frame_id, [59:40] render_interval_us,
   // [122:60] render_timestamp_us, [154:123] frame_count, [159:155] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   frame_rotator_board board = new();
   int                 send_idle = 22;
   int                 recv_idle = 62;
   int                 cycle_count = 0;
   logic [TIME_W-1:0]  stamp_us = '0;

   triple_buffer_frame_rotator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Status side: check each accepted beat, then stall at random for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata);
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // Offers one event beat, after a random gap, and holds it until it is taken.
   task automatic send_event(input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] stamp);
      if ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, stamp};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      board.note_event(mode, stamp);
   endtask

   // Stops sending and waits until every owed status beat has come back.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Writes a register, then reads it back.
   task automatic set_register(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_CAPTURE_ENABLED) begin
         board.capture_on = value[0];
         want = 32'(board.capture_on);
      end else begin
         board.max_gap_us = value[INTERVAL_W-1:0];
         want = 32'(board.max_gap_us);
      end
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // The port goes idle before the next transfer.
      @(posedge clock);
      if (readback !== want)
         board.report($sformatf("register %0h reads %0h, should be %0h", addr, readback, want));
   endtask

   // Mostly whole frames (start, done, often prepare) with random timing, plus noise.
   task automatic random_items(input int count);
      int                sent;
      int                pick;
      logic [TIME_W-1:0] gap;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_event(MODE_FRAME_START, stamp_us);
            case ($urandom_range(0, 5))
               0: gap = TIME_W'(board.max_gap_us);
               1: gap = TIME_W'(board.max_gap_us) + 1;
               2: gap = TIME_W'($urandom_range(0, 3000000));
               default: gap = TIME_W'($urandom_range(0, board.max_gap_us));
            endcase
            stamp_us += gap;
            send_event(MODE_CAPTURE_DONE, stamp_us);
            sent += 2;
            if ($urandom_range(0, 99) < 60) begin
               send_event(MODE_PREPARE_DISPLAY, stamp_us + 1);
               sent++;
            end
            stamp_us += TIME_W'($urandom_range(1, 500));
         end else if (pick < 82) begin
            send_event(MODE_W'($urandom_range(0, 3)), TIME_W'({$urandom, $urandom}));
            sent++;
         end else if (pick < 87) begin
            send_event(MODE_RESET_CAPTURE, stamp_us);
            sent++;
         end else if (pick < 94) begin
            // A done with no fresh start, sometimes stamped before the last start.
            send_event(MODE_CAPTURE_DONE, stamp_us - TIME_W'($urandom_range(0, 200)));
            sent++;
         end else begin
            stamp_us = TIME_W'({$urandom, $urandom});
            send_event(MODE_PREPARE_DISPLAY, stamp_us);
            sent++;
         end
      end
   endtask

   initial begin
      logic [31:0] limit_us;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Capture is off after reset: done and reset capture do nothing, start still counts.
      send_event(MODE_CAPTURE_DONE, 63'd100);
      send_event(MODE_RESET_CAPTURE, 63'd120);
      send_event(MODE_PREPARE_DISPLAY, 63'd130);
      send_event(MODE_FRAME_START, 63'd0);
      settle();
      set_register(ADDR_CAPTURE_ENABLED, 32'd1);
      set_register(ADDR_MAX_INTERVAL, 32'd100000);

      // Start at time zero is seen; done before start; interval at and just past the limit.
      send_event(MODE_CAPTURE_DONE, 63'd50);
      send_event(MODE_PREPARE_DISPLAY, 63'd60);
      send_event(MODE_FRAME_START, 63'd1000);
      send_event(MODE_CAPTURE_DONE, 63'd999);
      send_event(MODE_FRAME_START, 63'd2000);
      send_event(MODE_CAPTURE_DONE, 63'd102000);
      send_event(MODE_PREPARE_DISPLAY, 63'd102001);
      send_event(MODE_FRAME_START, 63'd5);
      send_event(MODE_CAPTURE_DONE, 63'd100006);
      send_event(MODE_RESET_CAPTURE, 63'd200000);
      send_event(MODE_CAPTURE_DONE, 63'd200010);
      send_event(MODE_PREPARE_DISPLAY, 63'd200020);
      send_event(MODE_FRAME_START, TIME_TOP);
      send_event(MODE_CAPTURE_DONE, TIME_TOP);
      send_event(MODE_CAPTURE_DONE, 63'd0);
      send_event(MODE_PREPARE_DISPLAY, 63'd1);
      settle();

      // Narrowest window: only a zero interval is kept.
      set_register(ADDR_MAX_INTERVAL, 32'd0);
      send_event(MODE_FRAME_START, 63'd7);
      send_event(MODE_CAPTURE_DONE, 63'd7);
      send_event(MODE_CAPTURE_DONE, 63'd8);
      settle();

      // Widest window.
      set_register(ADDR_MAX_INTERVAL, 32'd1000000);
      send_event(MODE_FRAME_START, 63'd0);
      send_event(MODE_CAPTURE_DONE, 63'd1000000);
      send_event(MODE_PREPARE_DISPLAY, 63'd1000001);
      stamp_us = 63'd2000000;

      // Random part in six stretches; each starts from a drained block with new settings.
      for (int phase = 0; phase < 6; phase++) begin
         settle();
         send_idle = (phase < 2) ? 22 : (phase < 4) ? 62 : 0;
         recv_idle = (phase < 2) ? 62 : (phase < 4) ? 22 : 0;
         case (phase)
            0: limit_us = 32'd100000;
            1: limit_us = $urandom_range(0, 1000);
            2: limit_us = 32'd1000000;
            3: limit_us = $urandom_range(0, 1000000);
            4: limit_us = 32'd0;
            default: limit_us = $urandom_range(50, 5000);
         endcase
         set_register(ADDR_CAPTURE_ENABLED, (phase == 3) ? 32'd0 : 32'd1);
         set_register(ADDR_MAX_INTERVAL, limit_us);
         random_items(185);
      end

      settle();
      if (board.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
